// ===== rtl/core/lmac_pkg.sv =====
package lmac_pkg;

    // table size and derived widths
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // field widths
    localparam int OP_W     = 2;
    localparam int LOCAL_W  = 8;
    localparam int MAC_W    = 48;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [MAC_W-1:0]   MAC_ONES = {MAC_W{1'b1}};
    localparam logic [LOCAL_W-1:0] BCAST_RESET = 8'hff;
    localparam logic [LOCAL_W-1:0] NULL_RESET  = 8'h00;

    // operation codes
    localparam logic [OP_W-1:0] OP_SET           = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_OWN       = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND_BY_MAC   = 2'd2;
    localparam logic [OP_W-1:0] OP_FIND_BY_LOCAL = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BROADCAST = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NULL      = 1'd1;

    typedef enum logic [1:0] {
        TBL_INSERT,
        TBL_FIND_LOCAL,
        TBL_FIND_MAC
    } tbl_op_t;

    typedef enum logic {
        TS_IDLE,
        TS_SCAN
    } tbl_state_t;

    typedef enum logic {
        T_IDLE,
        T_WAIT
    } top_state_t;

    typedef struct packed {
        logic [LOCAL_W-1:0] local_addr;
        logic [MAC_W-1:0]   mac_addr;
    } entry_t;

    typedef struct packed {
        logic               valid;
        tbl_op_t            kind;
        logic [LOCAL_W-1:0] local_key;
        logic [MAC_W-1:0]   mac_key;
    } tbl_req_t;

    typedef struct packed {
        logic               done;
        logic               hit;
        logic               full;
        logic [LOCAL_W-1:0] local_data;
        logic [MAC_W-1:0]   mac_data;
    } tbl_rsp_t;

endpackage

// ===== rtl/core/lmac_table.sv =====
module lmac_table (
    input  logic               clk,
    input  logic               rst_n,
    input  lmac_pkg::tbl_req_t req,
    output lmac_pkg::tbl_rsp_t rsp
);

    lmac_pkg::entry_t mem [lmac_pkg::TABLE_DEPTH];

    lmac_pkg::tbl_state_t             state_reg, state_next;
    logic [lmac_pkg::CNT_W-1:0]       idx_reg, idx_next;
    logic [lmac_pkg::CNT_W-1:0]       count_reg, count_next;
    lmac_pkg::tbl_op_t                kind_reg, kind_next;
    logic [lmac_pkg::LOCAL_W-1:0]     lkey_reg, lkey_next;
    logic [lmac_pkg::MAC_W-1:0]       mkey_reg, mkey_next;
    lmac_pkg::entry_t                 rd_data_reg;

    logic [lmac_pkg::CNT_W-1:0]       idx_inc;
    logic                             in_range;
    logic                             match;
    logic                             last;
    logic [lmac_pkg::IDX_W-1:0]       rd_addr;
    logic                             wr_en;
    logic [lmac_pkg::IDX_W-1:0]       wr_addr;

    // compare the entry read last cycle with the key
    assign idx_inc  = idx_reg + lmac_pkg::CNT_W'(1);
    assign in_range = (idx_reg < count_reg);
    assign last     = (idx_inc >= count_reg);
    assign match    = in_range && ((kind_reg == lmac_pkg::TBL_FIND_MAC) ?
                                   (rd_data_reg.mac_addr == mkey_reg) :
                                   (rd_data_reg.local_addr == lkey_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lmac_pkg::TS_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = lmac_pkg::TS_SCAN;
                end
            end
            lmac_pkg::TS_SCAN:
            begin
                if (match || last)
                begin
                    state_next = lmac_pkg::TS_IDLE;
                end
            end
            default: state_next = lmac_pkg::TS_IDLE;
        endcase
    end

    // scan control, write back and response
    always_comb
    begin
        idx_next   = idx_reg;
        count_next = count_reg;
        kind_next  = kind_reg;
        lkey_next  = lkey_reg;
        mkey_next  = mkey_reg;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = idx_reg[lmac_pkg::IDX_W-1:0];
        rsp        = '0;
        rsp.local_data = rd_data_reg.local_addr;
        rsp.mac_data   = rd_data_reg.mac_addr;
        case (state_reg)
            lmac_pkg::TS_IDLE:
            begin
                if (req.valid)
                begin
                    idx_next  = '0;
                    kind_next = req.kind;
                    lkey_next = req.local_key;
                    mkey_next = req.mac_key;
                end
            end
            lmac_pkg::TS_SCAN:
            begin
                rd_addr = idx_inc[lmac_pkg::IDX_W-1:0];
                if (match)
                begin
                    rsp.done = 1'b1;
                    rsp.hit  = 1'b1;
                    if (kind_reg == lmac_pkg::TBL_INSERT)
                    begin
                        wr_en = 1'b1;
                    end
                end
                else if (last)
                begin
                    rsp.done = 1'b1;
                    if (kind_reg == lmac_pkg::TBL_INSERT)
                    begin
                        if (count_reg < lmac_pkg::CNT_W'(lmac_pkg::TABLE_DEPTH))
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[lmac_pkg::IDX_W-1:0];
                            count_next = count_reg + lmac_pkg::CNT_W'(1);
                        end
                        else
                        begin
                            rsp.full = 1'b1;
                        end
                    end
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lmac_pkg::TS_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // scan index and key
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        kind_reg <= kind_next;
        lkey_reg <= lkey_next;
        mkey_reg <= mkey_next;
    end

    // entry memory, one registered read port and one write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {lkey_reg, mkey_reg};
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// ===== rtl/core/local_to_mac_address_cache_top.sv =====
// channel    | transfer when       | signals
// -----------+---------------------+-----------------------------------------
// command    | start && !busy      | operation, local_addr, mac_addr
// result     | done                | status, local_out, mac_out
// config     | wr_en               | wr_index, wr_data
//
// broadcast, own pair and set-own answers: done in the cycle after the command
// table operations scan the entry memory one entry per cycle: done follows
// the last entry examined, and busy holds while the scan runs
// reset clears the table count and the own pair and loads both config registers with their reset values
// the receiver cannot stall: each result shows on done for one cycle
module local_to_mac_address_cache_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [lmac_pkg::OP_W-1:0]         operation,
    input  logic [lmac_pkg::LOCAL_W-1:0]      local_addr,
    input  logic [lmac_pkg::MAC_W-1:0]        mac_addr,
    output logic                              done,
    output logic [lmac_pkg::STATUS_W-1:0]     status,
    output logic [lmac_pkg::LOCAL_W-1:0]      local_out,
    output logic [lmac_pkg::MAC_W-1:0]        mac_out,
    input  logic                              wr_en,
    input  logic [lmac_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [lmac_pkg::LOCAL_W-1:0]      wr_data
);

    lmac_pkg::top_state_t             state_reg, state_next;
    logic [lmac_pkg::OP_W-1:0]        op_reg, op_next;
    logic [lmac_pkg::LOCAL_W-1:0]     bcast_reg;
    logic [lmac_pkg::LOCAL_W-1:0]     null_reg;
    logic [lmac_pkg::LOCAL_W-1:0]     own_local_reg;
    logic [lmac_pkg::MAC_W-1:0]       own_mac_reg;
    logic                             done_reg;
    logic [lmac_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [lmac_pkg::LOCAL_W-1:0]     local_out_reg, local_out_next;
    logic [lmac_pkg::MAC_W-1:0]       mac_out_reg, mac_out_next;

    logic                             accept;
    logic                             own_set;
    logic                             own_we;
    logic                             res_we;
    lmac_pkg::tbl_req_t               req;
    lmac_pkg::tbl_rsp_t               rsp;

    assign busy    = (state_reg != lmac_pkg::T_IDLE);
    assign accept  = start && !busy;
    assign own_set = (own_local_reg != null_reg);

    assign done      = done_reg;
    assign status    = status_reg;
    assign local_out = local_out_reg;
    assign mac_out   = mac_out_reg;

    lmac_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lmac_pkg::T_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = lmac_pkg::T_WAIT;
                end
            end
            lmac_pkg::T_WAIT:
            begin
                if (rsp.done)
                begin
                    state_next = lmac_pkg::T_IDLE;
                end
            end
            default: state_next = lmac_pkg::T_IDLE;
        endcase
    end

    // command decode, fast answers and table results
    always_comb
    begin
        req            = '0;
        req.local_key  = local_addr;
        req.mac_key    = mac_addr;
        res_we         = 1'b0;
        own_we         = 1'b0;
        op_next        = op_reg;
        status_next    = lmac_pkg::ST_OK;
        local_out_next = '0;
        mac_out_next   = '0;
        case (state_reg)
            lmac_pkg::T_IDLE:
            begin
                if (accept)
                begin
                    op_next = operation;
                    case (operation)
                        lmac_pkg::OP_SET:
                        begin
                            if (local_addr == bcast_reg)
                            begin
                                res_we      = 1'b1;
                                status_next = lmac_pkg::ST_IGNORED;
                            end
                            else
                            begin
                                req.valid = 1'b1;
                                req.kind  = lmac_pkg::TBL_INSERT;
                            end
                        end
                        lmac_pkg::OP_SET_OWN:
                        begin
                            res_we = 1'b1;
                            if (own_set)
                            begin
                                status_next = lmac_pkg::ST_IGNORED;
                            end
                            else
                            begin
                                own_we = 1'b1;
                            end
                        end
                        lmac_pkg::OP_FIND_BY_MAC:
                        begin
                            if (mac_addr == lmac_pkg::MAC_ONES)
                            begin
                                res_we         = 1'b1;
                                local_out_next = bcast_reg;
                            end
                            else if (own_set && (own_mac_reg == mac_addr))
                            begin
                                res_we         = 1'b1;
                                local_out_next = own_local_reg;
                            end
                            else
                            begin
                                req.valid = 1'b1;
                                req.kind  = lmac_pkg::TBL_FIND_MAC;
                            end
                        end
                        default:
                        begin
                            if (local_addr == bcast_reg)
                            begin
                                res_we       = 1'b1;
                                mac_out_next = lmac_pkg::MAC_ONES;
                            end
                            else
                            begin
                                req.valid = 1'b1;
                                req.kind  = lmac_pkg::TBL_FIND_LOCAL;
                            end
                        end
                    endcase
                end
            end
            lmac_pkg::T_WAIT:
            begin
                if (rsp.done)
                begin
                    res_we = 1'b1;
                    case (op_reg)
                        lmac_pkg::OP_SET:
                        begin
                            if (rsp.full)
                            begin
                                status_next = lmac_pkg::ST_FULL;
                            end
                        end
                        lmac_pkg::OP_FIND_BY_MAC:
                        begin
                            if (rsp.hit)
                            begin
                                local_out_next = rsp.local_data;
                            end
                            else
                            begin
                                local_out_next = null_reg;
                                status_next    = lmac_pkg::ST_MISS;
                            end
                        end
                        default:
                        begin
                            if (rsp.hit)
                            begin
                                mac_out_next = rsp.mac_data;
                            end
                            else
                            begin
                                mac_out_next = lmac_pkg::MAC_ONES;
                                status_next  = lmac_pkg::ST_MISS;
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lmac_pkg::T_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= res_we;
        end
    end

    // pending operation and result payload
    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        if (res_we)
        begin
            status_reg    <= status_next;
            local_out_reg <= local_out_next;
            mac_out_reg   <= mac_out_next;
        end
    end

    // config registers and own pair; an unset own pair tracks the null value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcast_reg     <= lmac_pkg::BCAST_RESET;
            null_reg      <= lmac_pkg::NULL_RESET;
            own_local_reg <= lmac_pkg::NULL_RESET;
            own_mac_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                lmac_pkg::REG_BROADCAST:
                begin
                    bcast_reg <= wr_data;
                end
                lmac_pkg::REG_NULL:
                begin
                    if (!own_set)
                    begin
                        own_local_reg <= wr_data;
                    end
                    null_reg <= wr_data;
                end
                default: ;
            endcase
        end
        else if (own_we)
        begin
            own_local_reg <= local_addr;
            own_mac_reg   <= mac_addr;
        end
    end

endmodule

// ===== test/local_to_mac_address_cache_checker.sv =====
module local_to_mac_address_cache_checker
    import lmac_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [OP_W-1:0]      operation,
    input  logic [LOCAL_W-1:0]   local_addr,
    input  logic [MAC_W-1:0]     mac_addr,
    input  logic                 done,
    input  logic [STATUS_W-1:0]  status,
    input  logic [LOCAL_W-1:0]   local_out,
    input  logic [MAC_W-1:0]     mac_out,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [LOCAL_W-1:0]   wr_data,
    output int                   mismatches,
    output int                   outstanding
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LOCAL_W-1:0]  local_addr;
        logic [MAC_W-1:0]    mac_addr;
    } answer_t;

    // mirrored cache contents and registers
    logic [LOCAL_W-1:0] tbl_local [TABLE_DEPTH];
    logic [MAC_W-1:0]   tbl_mac   [TABLE_DEPTH];
    int                 entries;
    logic [LOCAL_W-1:0] own_loc;
    logic [MAC_W-1:0]   own_mac;
    logic [LOCAL_W-1:0] bcast_loc;
    logic [LOCAL_W-1:0] null_loc;

    answer_t expected_answers [$];
    int      error_total;

    // first valid slot holding this local address, entries if none
    function automatic int find_slot(logic [LOCAL_W-1:0] loc);
        int slot;
        slot = entries;
        for (int i = entries - 1; i >= 0; i--)
        begin
            if (tbl_local[i] == loc)
                slot = i;
        end
        return slot;
    endfunction

    // apply one command to the mirrored cache and return its answer
    function automatic answer_t resolve_command(logic [OP_W-1:0] op,
                                                logic [LOCAL_W-1:0] loc,
                                                logic [MAC_W-1:0] mac);
        answer_t ans;
        int      slot;
        bit      found;
        ans = '{status: ST_OK, local_addr: '0, mac_addr: '0};
        case (op)
            OP_SET:
            begin
                if (loc == bcast_loc)
                    ans.status = ST_IGNORED;
                else
                begin
                    slot = find_slot(loc);
                    if (slot < entries)
                        tbl_mac[slot] = mac;
                    else if (entries < TABLE_DEPTH)
                    begin
                        tbl_local[entries] = loc;
                        tbl_mac[entries]   = mac;
                        entries++;
                    end
                    else
                        ans.status = ST_FULL;
                end
            end
            OP_SET_OWN:
            begin
                // own pair counts as unset while it equals the null local
                if (own_loc != null_loc)
                    ans.status = ST_IGNORED;
                else
                begin
                    own_mac = mac;
                    own_loc = loc;
                end
            end
            OP_FIND_BY_MAC:
            begin
                if (mac == MAC_ONES)
                    ans.local_addr = bcast_loc;
                else if (own_loc != null_loc && own_mac == mac)
                    ans.local_addr = own_loc;
                else
                begin
                    found = 1'b0;
                    ans.local_addr = null_loc;
                    ans.status     = ST_MISS;
                    for (int i = 0; i < entries && !found; i++)
                    begin
                        if (tbl_mac[i] == mac)
                        begin
                            found          = 1'b1;
                            ans.local_addr = tbl_local[i];
                            ans.status     = ST_OK;
                        end
                    end
                end
            end
            default:
            begin
                // lookup by local never consults the own pair
                if (loc == bcast_loc)
                    ans.mac_addr = MAC_ONES;
                else
                begin
                    slot = find_slot(loc);
                    if (slot < entries)
                        ans.mac_addr = tbl_mac[slot];
                    else
                    begin
                        ans.mac_addr = MAC_ONES;
                        ans.status   = ST_MISS;
                    end
                end
            end
        endcase
        return ans;
    endfunction

    task automatic note_error(string what, logic [MAC_W-1:0] want, logic [MAC_W-1:0] got);
        error_total++;
        if (error_total <= 10)
            $display("%0t: %s expected %h actual %h", $time, what, want, got);
    endtask

    // compare result transfers, then track config writes and command transfers
    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            entries   = 0;
            own_loc   = NULL_RESET;
            own_mac   = '0;
            bcast_loc = BCAST_RESET;
            null_loc  = NULL_RESET;
            expected_answers.delete();
            error_total = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_answers.size() == 0)
                    note_error("result with nothing pending, mac_out", '0, mac_out);
                else
                begin
                    want = expected_answers.pop_front();
                    if (status != want.status)
                        note_error("status", MAC_W'(want.status), MAC_W'(status));
                    if (local_out != want.local_addr)
                        note_error("local_out", MAC_W'(want.local_addr), MAC_W'(local_out));
                    if (mac_out != want.mac_addr)
                        note_error("mac_out", want.mac_addr, mac_out);
                end
            end

            if (wr_en)
            begin
                if (wr_index == REG_BROADCAST)
                    bcast_loc = wr_data;
                else if (wr_index == REG_NULL)
                begin
                    // an unset own pair tracks the null value
                    if (own_loc == null_loc)
                        own_loc = wr_data;
                    null_loc = wr_data;
                end
            end

            if (start && !busy)
                expected_answers.insert(expected_answers.size(),
                                        resolve_command(operation, local_addr, mac_addr));
        end
        mismatches  <= error_total;
        outstanding <= expected_answers.size();
    end

endmodule

// ===== test/tb_local_to_mac_address_cache_top.sv =====
module tb_local_to_mac_address_cache_top;

    import lmac_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 24;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 start      = 1'b0;
    logic                 busy;
    logic [OP_W-1:0]      operation  = '0;
    logic [LOCAL_W-1:0]   local_addr = '0;
    logic [MAC_W-1:0]     mac_addr   = '0;
    logic                 done;
    logic [STATUS_W-1:0]  status;
    logic [LOCAL_W-1:0]   local_out;
    logic [MAC_W-1:0]     mac_out;
    logic                 wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0] wr_index   = '0;
    logic [LOCAL_W-1:0]   wr_data    = '0;
    int                   mismatches;
    int                   outstanding;

    int                   cycles = 0;
    bit                   steady = 1'b1;
    logic [MAC_W-1:0]     mac_pool [8];

    local_to_mac_address_cache_top dut (.*);

    local_to_mac_address_cache_checker checker_i (.*);

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [MAC_W-1:0] any_mac();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[MAC_W-1:0];
    endfunction

    // mostly a small set of addresses so that lookups hit and the table fills
    function automatic logic [LOCAL_W-1:0] pick_local();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return LOCAL_W'($urandom_range(0, 23));
        else if (r < 80)
            return 8'hff;
        else
            return LOCAL_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [MAC_W-1:0] pick_mac();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return mac_pool[$urandom_range(0, 7)];
        else if (r < 70)
            return MAC_ONES;
        else
            return any_mac();
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return OP_SET;
        else if (r < 45)
            return OP_SET_OWN;
        else if (r < 72)
            return OP_FIND_BY_MAC;
        else
            return OP_FIND_BY_LOCAL;
    endfunction

    // one command transfer, start left high afterwards
    task automatic send_command(logic [OP_W-1:0] op, logic [LOCAL_W-1:0] loc,
                                logic [MAC_W-1:0] mac);
        if (!steady && $urandom_range(0, 99) < 14)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start      <= 1'b1;
        operation  <= op;
        local_addr <= loc;
        mac_addr   <= mac;
        do @(posedge clk); while (busy);
    endtask

    // drop start and wait for every pending result
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_config(logic [LOCAL_W-1:0] bcast, logic [LOCAL_W-1:0] nul);
        wr_en    <= 1'b1;
        wr_index <= REG_BROADCAST;
        wr_data  <= bcast;
        @(posedge clk);
        wr_index <= REG_NULL;
        wr_data  <= nul;
        @(posedge clk);
        wr_en    <= 1'b0;
    endtask

    initial
    begin
        logic [LOCAL_W-1:0] bcast;
        logic [LOCAL_W-1:0] nul;

        mac_pool[0] = '0;
        for (int i = 1; i < 8; i++)
            mac_pool[i] = any_mac();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty table, broadcast, unset own pair, overwrite
        send_command(OP_FIND_BY_MAC, 8'h00, 48'h0);
        send_command(OP_FIND_BY_LOCAL, 8'h12, 48'h0);
        send_command(OP_FIND_BY_MAC, 8'h00, MAC_ONES);
        send_command(OP_FIND_BY_LOCAL, 8'hff, 48'h0);
        send_command(OP_SET, 8'hff, 48'h1);
        send_command(OP_SET_OWN, 8'h00, 48'h0000_1111_2222);
        send_command(OP_FIND_BY_MAC, 8'h00, 48'h0000_1111_2222);
        send_command(OP_SET, 8'h00, 48'h0);
        send_command(OP_SET, 8'hfe, MAC_ONES);
        send_command(OP_SET, 8'h01, 48'h0123_4567_89ab);
        send_command(OP_SET, 8'h01, 48'hfedc_ba98_7654);
        send_command(OP_FIND_BY_LOCAL, 8'h01, 48'h0);
        send_command(OP_FIND_BY_MAC, 8'h00, 48'hfedc_ba98_7654);
        send_command(OP_FIND_BY_MAC, 8'h00, 48'h0);
        send_command(OP_FIND_BY_LOCAL, 8'hfe, 48'h0);
        drain();

        // null moves while the own pair is unset
        write_config(8'h00, 8'h07);
        send_command(OP_SET_OWN, 8'h07, 48'h5);
        send_command(OP_SET_OWN, 8'h42, 48'ha5a5_a5a5_a5a5);
        send_command(OP_SET_OWN, 8'h43, 48'h5a5a_5a5a_5a5a);
        send_command(OP_FIND_BY_MAC, 8'h00, 48'ha5a5_a5a5_a5a5);
        send_command(OP_FIND_BY_LOCAL, 8'h42, 48'h0);
        send_command(OP_FIND_BY_LOCAL, 8'h00, 48'h0);
        send_command(OP_SET, 8'h00, 48'h3);
        send_command(OP_FIND_BY_MAC, 8'h00, 48'h123);
        drain();

        // random phases, each under its own register setting
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:
                begin
                    bcast = 8'hff;
                    nul   = 8'h00;
                end
                1:
                begin
                    bcast = 8'h00;
                    nul   = 8'hff;
                end
                default:
                begin
                    bcast = ($urandom_range(0, 1) != 0) ? 8'hff : pick_local();
                    case ($urandom_range(0, 3))
                        0:       nul = 8'h00;
                        1:       nul = 8'h42;
                        default: nul = pick_local();
                    endcase
                end
            endcase
            write_config(bcast, nul);
            for (int n = 0; n < 100; n++)
            begin
                // one phase runs without any idle cycles
                steady = (phase == 4);
                send_command(pick_op(), pick_local(), pick_mac());
            end
            drain();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/lmac_pkg.sv
rtl/core/lmac_table.sv
rtl/core/local_to_mac_address_cache_top.sv
test/local_to_mac_address_cache_checker.sv
test/tb_local_to_mac_address_cache_top.sv
